### hdl/baro_sensor_compensation_defines.svh
// Assertion macros shared by the compensation RTL.
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

`ifndef SYNTHESIS

`define BSC_AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define BSC_AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BSC_AST_IMPL(label, clk, rst_n, ante, cons)

`define BSC_AST_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/bsc_pkg.sv
// Shared widths, constants and register indexes of the compensation block.
`default_nettype none

package bsc_pkg;

	localparam int RawW    = 24;
	localparam int CalW    = 16;
	localparam int TempW   = 15;
	localparam int PresW   = 17;
	localparam int CfgIdxW = 3;

	localparam int TempMin = -4000;
	localparam int TempMax = 8500;
	localparam int PresMin = 1000;
	localparam int PresMax = 120000;

	typedef enum logic [CfgIdxW-1:0] {
		CfgC1 = 3'd0,
		CfgC2 = 3'd1,
		CfgC3 = 3'd2,
		CfgC4 = 3'd3,
		CfgC5 = 3'd4,
		CfgC6 = 3'd5
	} cfg_idx_t;

endpackage

`default_nettype wire

### hdl/bsc_in_if.sv
// Reading channel: raw pressure and temperature word.
`default_nettype none

interface bsc_in_if
	import bsc_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [RawW-1:0] raw_pressure;
	logic [RawW-1:0] raw_temperature;

	modport source(output valid, raw_pressure, raw_temperature, input ready);
	modport sink(input valid, raw_pressure, raw_temperature, output ready);
endinterface

`default_nettype wire

### hdl/bsc_out_if.sv
// Result channel: compensated temperature and pressure word.
`default_nettype none

interface bsc_out_if
	import bsc_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [TempW-1:0] temperature_centi;
	logic [PresW-1:0]        pressure_centi_mbar;
	logic                    out_of_range;

	modport source(output valid, temperature_centi, pressure_centi_mbar, out_of_range,
		input ready);
	modport sink(input valid, temperature_centi, pressure_centi_mbar, out_of_range,
		output ready);
endinterface

`default_nettype wire

### hdl/baro_sensor_compensation.sv
// Barometric sensor compensation: ten-stage pipeline, one reading word per cycle unless stalled.
//
// Takes one raw pressure/temperature word per clock unless stalled and returns
// the compensated temperature (0.01 C) and pressure (0.01 mbar) with second-order
// correction, clamped to -40.00..85.00 C and 10.00..1200.00 mbar; out_of_range
// marks a clamp. A new word is accepted every clock while not stalled; the ten
// register stages (multiplier stages for dT products, squares and the split
// pressure product) each hold one word in flight. Stalls on the result side fill
// bubbles first; ready drops only when all ten stages hold words and the result
// is not taken. Calibration words C1..C6 are written at indexes 0..5 and must be
// stable while words are in flight.
`default_nettype none

`include "baro_sensor_compensation_defines.svh"

module baro_sensor_compensation
	import bsc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CalW-1:0]    cfg_wdata,
	bsc_in_if.sink                  reading,
	bsc_out_if.source               result
);

	localparam int NumStg = 10;

	logic [CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	logic [NumStg-1:0] vld_q;
	logic [NumStg-1:0] en;

	// stage 1
	logic [RawW-1:0]    d1_s1;
	logic signed [24:0] dt_s1;
	// stage 2
	logic [RawW-1:0]    d1_s2;
	logic signed [41:0] t6_s2, o4_s2, sc3_s2;
	logic signed [49:0] dtsq_s2;
	// stage 3
	logic [RawW-1:0]    d1_s3;
	logic signed [19:0] temp_s3;
	logic signed [18:0] a_s3, b_s3;
	logic               lt_s3, ltm_s3;
	logic signed [35:0] off_s3, sens_s3;
	logic [17:0]        t2_s3;
	// stage 4
	logic [RawW-1:0]    d1_s4;
	logic signed [20:0] temp_s4;
	logic [34:0]        sq_s4, sq2_s4;
	logic               lt_s4, ltm_s4;
	logic signed [35:0] off_s4, sens_s4;
	// stage 5
	logic [RawW-1:0]    d1_s5;
	logic [TempW-1:0]   tcl_s5;
	logic               tflag_s5;
	logic [38:0]        off2_s5, sens2_s5;
	logic signed [35:0] off_s5, sens_s5;
	// stage 6
	logic [RawW-1:0]    d1_s6;
	logic [TempW-1:0]   tcl_s6;
	logic               tflag_s6;
	logic signed [39:0] offf_s6, sensf_s6;
	// stage 7
	logic [TempW-1:0]   tcl_s7;
	logic               tflag_s7;
	logic signed [39:0] offf_s7;
	logic [43:0]        pl_s7;
	logic signed [44:0] ph_s7;
	// stage 8
	logic [TempW-1:0]   tcl_s8;
	logic               tflag_s8;
	logic signed [39:0] offf_s8;
	logic signed [63:0] prod_s8;
	// stage 9
	logic [TempW-1:0]   tcl_s9;
	logic               tflag_s9;
	logic signed [28:0] p_s9;
	// stage 10
	logic [TempW-1:0]   temp_s10;
	logic [PresW-1:0]   pres_s10;
	logic               oor_s10;

	logic signed [18:0] delta;
	logic signed [37:0] asq, bsq;
	logic [37:0]        five_sq, seven_sq2;
	logic [38:0]        eleven_sq2;
	logic signed [43:0] pdiff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CfgC1: c1_q <= cfg_wdata;
				CfgC2: c2_q <= cfg_wdata;
				CfgC3: c3_q <= cfg_wdata;
				CfgC4: c4_q <= cfg_wdata;
				CfgC5: c5_q <= cfg_wdata;
				CfgC6: c6_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its successor moves on
	always_comb begin
		en[NumStg-1] = !vld_q[NumStg-1] || result.ready;
		for (int i = NumStg - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= reading.valid;
			for (int i = 1; i < NumStg; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign delta = t6_s2[41:23];
	assign asq   = a_s3 * a_s3;
	assign bsq   = b_s3 * b_s3;

	assign five_sq    = {1'b0, sq_s4, 2'b0} + {3'b0, sq_s4};
	assign seven_sq2  = {sq2_s4, 3'b0} - {3'b0, sq2_s4};
	assign eleven_sq2 = {1'b0, sq2_s4, 3'b0} + {3'b0, sq2_s4, 1'b0} + {4'b0, sq2_s4};

	assign pdiff = {prod_s8[63], prod_s8[63:21]} - {{4{offf_s8[39]}}, offf_s8};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s1 <= reading.raw_pressure;
			dt_s1 <= $signed({1'b0, reading.raw_temperature}) - $signed({1'b0, c5_q, 8'b0});
		end
		if (en[1]) begin
			d1_s2   <= d1_s1;
			t6_s2   <= dt_s1 * $signed({1'b0, c6_q});
			o4_s2   <= dt_s1 * $signed({1'b0, c4_q});
			sc3_s2  <= dt_s1 * $signed({1'b0, c3_q});
			dtsq_s2 <= dt_s1 * dt_s1;
		end
		if (en[2]) begin
			d1_s3   <= d1_s2;
			temp_s3 <= {delta[18], delta} + 20'sd2000;
			a_s3    <= delta;
			b_s3    <= delta + 19'sd3500;
			lt_s3   <= delta[18];
			ltm_s3  <= delta < -19'sd3500;
			off_s3  <= $signed({4'b0, c2_q, 16'b0}) + {o4_s2[41], o4_s2[41:7]};
			sens_s3 <= $signed({5'b0, c1_q, 15'b0}) + {{2{sc3_s2[41]}}, sc3_s2[41:8]};
			t2_s3   <= dtsq_s2[48:31];
		end
		if (en[3]) begin
			d1_s4   <= d1_s3;
			// T2 applies only below 20.00 C
			temp_s4 <= {temp_s3[19], temp_s3} - (lt_s3 ? {3'b0, t2_s3} : 21'd0);
			sq_s4   <= asq[34:0];
			sq2_s4  <= bsq[34:0];
			lt_s4   <= lt_s3;
			ltm_s4  <= ltm_s3;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
		end
		if (en[4]) begin
			d1_s5   <= d1_s4;
			off_s5  <= off_s4;
			sens_s5 <= sens_s4;
			if (temp_s4 < TempMin) begin
				tcl_s5   <= TempW'(TempMin);
				tflag_s5 <= 1'b1;
			end else if (temp_s4 > TempMax) begin
				tcl_s5   <= TempW'(TempMax);
				tflag_s5 <= 1'b1;
			end else begin
				tcl_s5   <= temp_s4[TempW-1:0];
				tflag_s5 <= 1'b0;
			end
			if (!lt_s4) begin
				off2_s5  <= '0;
				sens2_s5 <= '0;
			end else if (ltm_s4) begin
				off2_s5  <= {2'b0, five_sq[37:1]} + {1'b0, seven_sq2};
				sens2_s5 <= {3'b0, five_sq[37:2]} + {1'b0, eleven_sq2[38:1]};
			end else begin
				off2_s5  <= {2'b0, five_sq[37:1]};
				sens2_s5 <= {3'b0, five_sq[37:2]};
			end
		end
		if (en[5]) begin
			d1_s6    <= d1_s5;
			tcl_s6   <= tcl_s5;
			tflag_s6 <= tflag_s5;
			offf_s6  <= {{4{off_s5[35]}}, off_s5} - {1'b0, off2_s5};
			sensf_s6 <= {{4{sens_s5[35]}}, sens_s5} - {1'b0, sens2_s5};
		end
		if (en[6]) begin
			tcl_s7   <= tcl_s6;
			tflag_s7 <= tflag_s6;
			offf_s7  <= offf_s6;
			pl_s7    <= d1_s6 * sensf_s6[19:0];
			ph_s7    <= $signed({1'b0, d1_s6}) * $signed(sensf_s6[39:20]);
		end
		if (en[7]) begin
			tcl_s8   <= tcl_s7;
			tflag_s8 <= tflag_s7;
			offf_s8  <= offf_s7;
			prod_s8  <= {ph_s7[43:0], 20'b0} + {20'b0, pl_s7};
		end
		if (en[8]) begin
			tcl_s9   <= tcl_s8;
			tflag_s9 <= tflag_s8;
			p_s9     <= pdiff[43:15];
		end
		if (en[9]) begin
			temp_s10 <= tcl_s9;
			if (p_s9 < PresMin) begin
				pres_s10 <= PresW'(PresMin);
				oor_s10  <= 1'b1;
			end else if (p_s9 > PresMax) begin
				pres_s10 <= PresW'(PresMax);
				oor_s10  <= 1'b1;
			end else begin
				pres_s10 <= p_s9[PresW-1:0];
				oor_s10  <= tflag_s9;
			end
		end
	end

	assign reading.ready              = en[0];
	assign result.valid               = vld_q[NumStg-1];
	assign result.temperature_centi   = temp_s10;
	assign result.pressure_centi_mbar = pres_s10;
	assign result.out_of_range        = oor_s10;

	`BSC_AST_NEXT(a_accept_enters, clk, arst_n, reading.valid && reading.ready, vld_q[0])
	`BSC_AST_IMPL(a_full_when_blocked, clk, arst_n, !reading.ready, &vld_q)
	`BSC_AST_IMPL(a_temp_in_range, clk, arst_n, result.valid, $signed(temp_s10) >= TempMin && $signed(temp_s10) <= TempMax)
	`BSC_AST_IMPL(a_pres_in_range, clk, arst_n, result.valid, pres_s10 >= PresMin && pres_s10 <= PresMax)

endmodule

`default_nettype wire
